// ----- design/abcd_pkg.sv -----
`default_nettype none
// Shared widths, register codes, field tables and helpers for the ARINC 429 BCD field codec.
package abcd_pkg;

    localparam int WORD_W      = 32;
    localparam int MAG_W       = 20;
    localparam int DEC_W       = 19;
    localparam int LAYOUT_W    = 2;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    // Six digit fields at most, four bits each at most.
    localparam int MAX_FIELDS  = 6;
    localparam int DIGIT_W     = 4;
    localparam int NUM_TABS    = 4;

    // Binary to BCD conversion: seven BCD digits cover a 20-bit magnitude.
    localparam int BCD_DIGITS     = 7;
    localparam int DD_W           = MAG_W + BCD_DIGITS * DIGIT_W;
    localparam int DD_STAGE_STEPS = 5;

    // Weighted digits are summed at this width; the sum always fits.
    localparam int PROD_W = 21;

    localparam logic [DEC_W-1:0] DEC_MAX = 19'd266665;

    // Sign/status matrix bits, ARINC bits 30 and 31.
    localparam int SSM_LO = 29;
    localparam int SSM_HI = 30;

    localparam logic [LAYOUT_W-1:0] LAYOUT_STD  = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_FLNO = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_ATC  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LAYOUT      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 1'b1;

    localparam logic [LAYOUT_W-1:0]  LAYOUT_RESET = LAYOUT_STD;
    localparam logic [COUNT_W-1:0]   COUNT_RESET  = 3'd5;

    typedef enum logic [1:0] {
        TAB_STD5 = 2'd0,
        TAB_STD6 = 2'd1,
        TAB_FLNO = 2'd2,
        TAB_ATC  = 2'd3
    } tab_t;

    typedef struct packed {
        tab_t               tab;
        logic [COUNT_W-1:0] nf;
        logic [COUNT_W-1:0] nd;
    } sel_t;

    // Low word bit of each field, most significant digit first.
    localparam logic [4:0] FIELD_LO [NUM_TABS][MAX_FIELDS] = '{
        '{5'd26, 5'd22, 5'd18, 5'd14, 5'd10, 5'd0},
        '{5'd28, 5'd24, 5'd20, 5'd16, 5'd12, 5'd8},
        '{5'd25, 5'd21, 5'd17, 5'd13, 5'd0,  5'd0},
        '{5'd26, 5'd23, 5'd20, 5'd17, 5'd0,  5'd0}
    };

    localparam logic [DIGIT_W-1:0] FIELD_MASK [NUM_TABS][MAX_FIELDS] = '{
        '{4'h7, 4'hF, 4'hF, 4'hF, 4'hF, 4'h0},
        '{4'h1, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF},
        '{4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'h0},
        '{4'h7, 4'h7, 4'h7, 4'h7, 4'h0, 4'h0}
    };

    localparam logic [PROD_W-1:0] POW10 [MAX_FIELDS] = '{
        21'd1, 21'd10, 21'd100, 21'd1000, 21'd10000, 21'd100000
    };

    // Chooses the field table, the number of fields written or read and the
    // number of digits that form the value.
    function automatic sel_t pick(input logic [LAYOUT_W-1:0] layout,
                                  input logic [COUNT_W-1:0]  count,
                                  input logic                encode);
        sel_t s;
        logic [COUNT_W-1:0] clamped;
        s.tab   = TAB_STD5;
        s.nf    = '0;
        s.nd    = '0;
        clamped = (count > 3'd4) ? 3'd4 : count;
        case (layout)
            LAYOUT_STD:
            begin
                if (count >= 3'd1 && count <= 3'd5)
                begin
                    s.nf = count;
                    s.nd = count;
                end
                else if (count == 3'd6)
                begin
                    s.tab = TAB_STD6;
                    s.nf  = 3'd6;
                    s.nd  = 3'd6;
                end
            end
            LAYOUT_FLNO:
            begin
                s.tab = TAB_FLNO;
                if (encode)
                begin
                    if (count >= 3'd1 && count <= 3'd4)
                    begin
                        s.nf = count;
                        s.nd = count;
                    end
                    else if (count == 3'd5)
                    begin
                        s.nf = 3'd4;
                        s.nd = 3'd5;
                    end
                end
                else
                begin
                    s.nf = clamped;
                    s.nd = clamped;
                end
            end
            LAYOUT_ATC:
            begin
                s.tab = TAB_ATC;
                if (encode)
                begin
                    if (count >= 3'd1 && count <= 3'd4)
                    begin
                        s.nf = count;
                        s.nd = count;
                    end
                end
                else
                begin
                    s.nf = clamped;
                    s.nd = clamped;
                end
            end
            default:
            begin
                s.nf = '0;
            end
        endcase
        return s;
    endfunction

    // Five shift-and-add-three steps of the binary to BCD conversion.
    function automatic logic [DD_W-1:0] dd_run(input logic [DD_W-1:0] s_in);
        logic [DD_W-1:0] s;
        int st;
        int d;
        s = s_in;
        for (st = 0; st < DD_STAGE_STEPS; st++)
        begin
            for (d = 0; d < BCD_DIGITS; d++)
            begin
                if (s[MAG_W + DIGIT_W*d +: DIGIT_W] >= 4'd5)
                    s[MAG_W + DIGIT_W*d +: DIGIT_W] = s[MAG_W + DIGIT_W*d +: DIGIT_W] + 4'd3;
            end
            s = s << 1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- design/abcd_in_if.sv -----
`default_nettype none
// Request channel: one word to decode or one magnitude to encode per transaction.
interface abcd_in_if;
    import abcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [WORD_W-1:0]  word_in;
    logic [MAG_W-1:0]   magnitude;
    logic               negative;

    modport source (output valid, kind, word_in, magnitude, negative, input ready);
    modport sink   (input valid, kind, word_in, magnitude, negative, output ready);
endinterface
`default_nettype wire

// ----- design/abcd_out_if.sv -----
`default_nettype none
// Result channel: the updated word and the decoded value per transaction.
interface abcd_out_if;
    import abcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  word_out;
    logic [DEC_W-1:0]   decoded_value;

    modport source (output valid, word_out, decoded_value, input ready);
    modport sink   (input valid, word_out, decoded_value, output ready);
endinterface
`default_nettype wire

// ----- design/arinc429_bcd_field_codec.sv -----
`default_nettype none
// Top level: five-stage pipelined ARINC 429 BCD field encoder and decoder.
// Each transaction passes through five register stages, s1 to s5, on its way to the result channel.
// Throughput: one transaction per cycle while the result side is ready; the binary to BCD conversion spreads its
// twenty shift steps over four stages and sets the depth.
// A stalled stage holds its contents; empty stages upstream still fill.
// Reset clears all stage valid bits and sets layout to standard and digit count to five.
module arinc429_bcd_field_codec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [abcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [abcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    abcd_in_if.sink                           item,
    abcd_out_if.source                        result
);
    import abcd_pkg::*;

    logic [LAYOUT_W-1:0] layout_reg;
    logic [COUNT_W-1:0]  digit_count_reg;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    logic              s1_kind_reg, s2_kind_reg, s3_kind_reg, s4_kind_reg;
    logic              s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg;
    logic [WORD_W-1:0] s1_word_reg, s2_word_reg, s3_word_reg, s4_word_reg;
    logic [DD_W-1:0]   s1_dd_reg, s2_dd_reg, s3_dd_reg, s4_dd_reg;

    logic [DIGIT_W-1:0] fld [MAX_FIELDS];
    logic [DIGIT_W-1:0] s1_slot_next [MAX_FIELDS];
    logic [DIGIT_W-1:0] s1_slot_reg [MAX_FIELDS];
    logic [PROD_W-1:0]  s2_prod_reg [MAX_FIELDS];
    logic [PROD_W-1:0]  s3_pair_reg [3];
    logic [PROD_W-1:0]  s4_sum_reg;

    logic [DIGIT_W-1:0] enc_digit [MAX_FIELDS];
    logic [WORD_W-1:0]  word5_next;
    logic [DEC_W-1:0]   dec5_next;
    logic [WORD_W-1:0]  word5_reg;
    logic [DEC_W-1:0]   dec5_reg;

    sel_t sel_dec;
    sel_t sel_enc;

    // Each stage moves on when it is empty or the stage after it moves on.
    assign adv5 = !s5_v_reg || result.ready;
    assign adv4 = !s4_v_reg || adv5;
    assign adv3 = !s3_v_reg || adv4;
    assign adv2 = !s2_v_reg || adv3;
    assign adv1 = !s1_v_reg || adv2;

    assign item.ready           = adv1;
    assign result.valid         = s5_v_reg;
    assign result.word_out      = word5_reg;
    assign result.decoded_value = dec5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg      <= LAYOUT_RESET;
            digit_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAYOUT:      layout_reg      <= cfg_data[LAYOUT_W-1:0];
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[COUNT_W-1:0];
                default:         layout_reg      <= layout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_v_reg <= item.valid;
            if (adv2) s2_v_reg <= s1_v_reg;
            if (adv3) s3_v_reg <= s2_v_reg;
            if (adv4) s4_v_reg <= s3_v_reg;
            if (adv5) s5_v_reg <= s4_v_reg;
        end
    end

    // Decode side: pull the fields out of the word and place each one at the
    // slot of its power of ten; unused slots are zero.
    always_comb
    begin
        logic [WORD_W-1:0] shifted;
        sel_dec = pick(layout_reg, digit_count_reg, 1'b0);
        for (int i = 0; i < MAX_FIELDS; i++)
        begin
            shifted = item.word_in >> FIELD_LO[sel_dec.tab][i];
            fld[i]  = shifted[DIGIT_W-1:0] & FIELD_MASK[sel_dec.tab][i];
        end
        for (int p = 0; p < MAX_FIELDS; p++)
        begin
            s1_slot_next[p] = '0;
            if (3'(p) < sel_dec.nf)
                s1_slot_next[p] = fld[3'(sel_dec.nf - 3'(p) - 3'd1)];
        end
    end

    // Encode side: write the BCD digits into the digit fields, and the sign into the SSM in standard layout.
    always_comb
    begin
        logic [WORD_W-1:0]  w;
        logic [WORD_W-1:0]  fmask;
        logic [COUNT_W-1:0] k;
        logic [DIGIT_W-1:0] digit;
        sel_enc = pick(layout_reg, digit_count_reg, 1'b1);
        for (int d = 0; d < MAX_FIELDS; d++)
            enc_digit[d] = s4_dd_reg[MAG_W + DIGIT_W*d +: DIGIT_W];
        w = s4_word_reg;
        for (int i = 0; i < MAX_FIELDS; i++)
        begin
            k     = sel_enc.nd - 3'(i) - 3'd1;
            digit = enc_digit[k] & FIELD_MASK[sel_enc.tab][i];
            fmask = {{(WORD_W-DIGIT_W){1'b0}}, FIELD_MASK[sel_enc.tab][i]}
                    << FIELD_LO[sel_enc.tab][i];
            if (3'(i) < sel_enc.nf)
                w = (w & ~fmask)
                    | ({{(WORD_W-DIGIT_W){1'b0}}, digit} << FIELD_LO[sel_enc.tab][i]);
        end
        if (layout_reg == LAYOUT_STD)
            w[SSM_HI:SSM_LO] = {2{s4_neg_reg}};
        word5_next = s4_kind_reg ? w : s4_word_reg;
        dec5_next  = s4_kind_reg ? '0 : s4_sum_reg[DEC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_kind_reg <= item.kind;
            s1_neg_reg  <= item.negative;
            s1_word_reg <= item.word_in;
            s1_dd_reg   <= dd_run({{(BCD_DIGITS*DIGIT_W){1'b0}}, item.magnitude});
            s1_slot_reg <= s1_slot_next;
        end
        if (adv2)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_word_reg <= s1_word_reg;
            s2_dd_reg   <= dd_run(s1_dd_reg);
            for (int p = 0; p < MAX_FIELDS; p++)
                s2_prod_reg[p] <= PROD_W'(s1_slot_reg[p]) * POW10[p];
        end
        if (adv3)
        begin
            s3_kind_reg    <= s2_kind_reg;
            s3_neg_reg     <= s2_neg_reg;
            s3_word_reg    <= s2_word_reg;
            s3_dd_reg      <= dd_run(s2_dd_reg);
            s3_pair_reg[0] <= s2_prod_reg[0] + s2_prod_reg[1];
            s3_pair_reg[1] <= s2_prod_reg[2] + s2_prod_reg[3];
            s3_pair_reg[2] <= s2_prod_reg[4] + s2_prod_reg[5];
        end
        if (adv4)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_word_reg <= s3_word_reg;
            s4_dd_reg   <= dd_run(s3_dd_reg);
            s4_sum_reg  <= s3_pair_reg[0] + s3_pair_reg[1] + s3_pair_reg[2];
        end
        if (adv5)
        begin
            word5_reg <= word5_next;
            dec5_reg  <= dec5_next;
        end
    end

    // An empty output stage must never hold back the request side.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !s5_v_reg |-> item.ready)
        else $error("request side stalled with an empty output stage");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> s1_v_reg)
        else $error("accepted transaction did not reach the first stage");

    a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s4_v_reg && !adv4 |=> s4_v_reg && $stable(s4_word_reg) && $stable(s4_sum_reg))
        else $error("stalled stage four lost or changed its contents");

    a_decoded_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.decoded_value <= DEC_MAX)
        else $error("decoded value above the largest field sum");

endmodule
`default_nettype wire
